### rtl/bcsd_pkg.sv
`default_nettype none
package bcsd_pkg;

   typedef enum logic [1:0] {
      OP_FRAME    = 2'd0,
      OP_REGISTER = 2'd1,
      OP_STEP     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_PRESS   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_HELD    = 2'd2,
      KIND_SEQ     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      RES_MATCH      = 3'd0,
      RES_SUMMARY    = 3'd1,
      RES_REGISTERED = 3'd2,
      RES_FULL       = 3'd3,
      RES_STEP       = 3'd4
   } result_type;

   typedef enum logic [1:0] {
      SEL_MATCH    = 2'd0,
      SEL_SUMMARY  = 2'd1,
      SEL_REGISTER = 2'd2,
      SEL_STEP     = 2'd3
   } out_sel_type;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 64;

   typedef struct packed {
      logic        clear_step;
      logic        capture;
      logic        frame_update;
      logic        do_register;
      logic        step_write;
      logic        table_read;
      logic        next_slot;
      logic        seq_init;
      logic        seq_read;
      logic        seq_advance;
      logic        seq_hit;
      logic        load_out;
      out_sel_type out_sel;
      logic        out_last;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   clear_done;
      logic   slot_end;
      logic   simple_hit;
      logic   is_seq;
      logic   seq_ok;
      logic   window_done;
      logic   step_match;
      logic   len_one;
      logic   out_last;
   } dp_status_type;

endpackage
`default_nettype wire

### rtl/bcsd_dp.sv
`default_nettype none
module bcsd_dp #(
   parameter int HISTORY_DEPTH = 60,
   parameter int MAX_COMMANDS  = 32,
   parameter int MAX_STEPS     = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bcsd_pkg::dp_cmd_type          cmd,
   output bcsd_pkg::dp_status_type            status,
   input  wire logic [bcsd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]                    req_tuser,
   output logic [bcsd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [2:0]                         rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int HAW = $clog2(HISTORY_DEPTH);
   localparam int CW  = $clog2(MAX_COMMANDS + 1);
   localparam int TAW = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
   localparam int SD  = MAX_COMMANDS * MAX_STEPS;
   localparam int SAW = (SD > 1) ? $clog2(SD) : 1;

   // captured request
   logic [1:0]  op_ff;
   logic [15:0] joy_ff, mask_in_ff, smask_ff;
   logic [1:0]  kind_in_ff;
   logic [3:0]  len_in_ff;
   logic [7:0]  dur_ff, id_in_ff;
   logic [4:0]  slot_in_ff;
   logic [2:0]  idx_ff;

   logic [15:0] hist_mem [HISTORY_DEPTH];
   logic [15:0] step_mem [SD];
   logic [1:0]  t_kind [MAX_COMMANDS];
   logic [15:0] t_mask [MAX_COMMANDS];
   logic [3:0]  t_len  [MAX_COMMANDS];
   logic [7:0]  t_win  [MAX_COMMANDS];
   logic [7:0]  t_id   [MAX_COMMANDS];

   logic [15:0] hist_rd_ff, step_rd_ff, t_mask_rd_ff;
   logic [1:0]  t_kind_rd_ff;
   logic [3:0]  t_len_rd_ff;
   logic [7:0]  t_win_rd_ff, t_id_rd_ff;

   logic [15:0]    cur_ff, press_ff, rel_ff;
   logic [HAW-1:0] wp_ff, pos_ff, clr_ff;
   logic [CW-1:0]  count_ff, slot_ff;
   logic [3:0]     len_ff;
   logic [7:0]     iter_ff;
   logic           fired_ff;

   logic [2:0]  okind_ff;
   logic [7:0]  oid_ff;
   logic [4:0]  oslot_ff;
   logic [15:0] oheld_ff, opr_ff, orl_ff;
   logic        olast_ff;

   logic [2:0]  okind_in;
   logic [7:0]  oid_in;
   logic [4:0]  oslot_in;
   logic [15:0] oheld_in, opr_in, orl_in;

   logic [HAW-1:0] pos_dec, wp_in;
   logic [SAW-1:0] step_rd_addr, step_wr_addr;
   logic           step_wr_ok, table_full;
   logic [3:0]     len_clamped;
   logic           simple_hit;

   assign pos_dec = (pos_ff == '0) ? HAW'(HISTORY_DEPTH - 1) : pos_ff - 1'b1;
   assign wp_in   = (wp_ff == HAW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign step_rd_addr = SAW'(32'(slot_ff[TAW-1:0]) * MAX_STEPS + 32'(len_ff) - 1);
   assign step_wr_addr = SAW'(32'(slot_in_ff) * MAX_STEPS + 32'(idx_ff));
   assign step_wr_ok   = (32'(slot_in_ff) < MAX_COMMANDS) && (32'(idx_ff) < MAX_STEPS);
   assign table_full   = (count_ff == CW'(MAX_COMMANDS));
   assign len_clamped  = (32'(len_in_ff) > MAX_STEPS) ? 4'(MAX_STEPS) : len_in_ff;

   always_comb begin
      unique case (bcsd_pkg::kind_type'(t_kind_rd_ff))
         bcsd_pkg::KIND_PRESS:   simple_hit = |(press_ff & t_mask_rd_ff);
         bcsd_pkg::KIND_RELEASE: simple_hit = |(rel_ff & t_mask_rd_ff);
         bcsd_pkg::KIND_HELD:    simple_hit = |(cur_ff & t_mask_rd_ff);
         default:                simple_hit = 1'b0;
      endcase
   end

   always_comb begin
      status.op          = bcsd_pkg::op_type'(op_ff);
      status.clear_done  = (clr_ff == HAW'(HISTORY_DEPTH - 1));
      status.slot_end    = (slot_ff >= count_ff);
      status.simple_hit  = simple_hit;
      status.is_seq      = (t_kind_rd_ff == bcsd_pkg::KIND_SEQ);
      status.seq_ok      = !fired_ff && (t_len_rd_ff != 4'd0);
      status.window_done = (iter_ff == t_win_rd_ff);
      status.step_match  = ((hist_rd_ff & step_rd_ff) == step_rd_ff);
      status.len_one     = (len_ff == 4'd1);
      status.out_last    = olast_ff;
   end

   // response word for the selected result
   always_comb begin
      okind_in = bcsd_pkg::RES_MATCH;
      oid_in   = '0;
      oslot_in = '0;
      oheld_in = '0;
      opr_in   = '0;
      orl_in   = '0;
      unique case (cmd.out_sel)
         bcsd_pkg::SEL_MATCH: begin
            oid_in   = t_id_rd_ff;
            oslot_in = 5'(slot_ff);
         end
         bcsd_pkg::SEL_SUMMARY: begin
            okind_in = bcsd_pkg::RES_SUMMARY;
            oheld_in = cur_ff;
            opr_in   = press_ff;
            orl_in   = rel_ff;
         end
         bcsd_pkg::SEL_REGISTER: begin
            oid_in = id_in_ff;
            if (table_full) begin
               okind_in = bcsd_pkg::RES_FULL;
            end else begin
               okind_in = bcsd_pkg::RES_REGISTERED;
               oslot_in = 5'(count_ff);
            end
         end
         bcsd_pkg::SEL_STEP: begin
            okind_in = bcsd_pkg::RES_STEP;
            oslot_in = slot_in_ff;
         end
         default: ;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         hist_mem[clr_ff] <= '0;
      end else if (cmd.frame_update) begin
         hist_mem[wp_ff] <= joy_ff;
      end
      if (cmd.seq_read) begin
         hist_rd_ff <= hist_mem[pos_dec];
         step_rd_ff <= step_mem[step_rd_addr];
      end
      if (cmd.step_write && step_wr_ok) begin
         step_mem[step_wr_addr] <= smask_ff;
      end
      if (cmd.do_register && !table_full) begin
         t_kind[count_ff[TAW-1:0]] <= kind_in_ff;
         t_mask[count_ff[TAW-1:0]] <= mask_in_ff;
         t_len[count_ff[TAW-1:0]]  <= len_clamped;
         t_win[count_ff[TAW-1:0]]  <= dur_ff;
         t_id[count_ff[TAW-1:0]]   <= id_in_ff;
      end
      if (cmd.table_read) begin
         t_kind_rd_ff <= t_kind[slot_ff[TAW-1:0]];
         t_mask_rd_ff <= t_mask[slot_ff[TAW-1:0]];
         t_len_rd_ff  <= t_len[slot_ff[TAW-1:0]];
         t_win_rd_ff  <= t_win[slot_ff[TAW-1:0]];
         t_id_rd_ff   <= t_id[slot_ff[TAW-1:0]];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_tuser;
         joy_ff     <= req_tdata[15:0];
         kind_in_ff <= req_tdata[17:16];
         mask_in_ff <= req_tdata[33:18];
         len_in_ff  <= req_tdata[37:34];
         dur_ff     <= req_tdata[45:38];
         id_in_ff   <= req_tdata[53:46];
         slot_in_ff <= req_tdata[58:54];
         idx_ff     <= req_tdata[61:59];
         smask_ff   <= req_tdata[77:62];
      end
      if (cmd.seq_init) begin
         len_ff  <= t_len_rd_ff;
         pos_ff  <= wp_ff;
         iter_ff <= '0;
      end else if (cmd.seq_read) begin
         pos_ff  <= pos_dec;
         iter_ff <= iter_ff + 1'b1;
      end else if (cmd.seq_advance) begin
         len_ff <= len_ff - 1'b1;
      end
      if (cmd.load_out) begin
         olast_ff <= cmd.out_last;
         okind_ff <= okind_in;
         oid_ff   <= oid_in;
         oslot_ff <= oslot_in;
         oheld_ff <= oheld_in;
         opr_ff   <= opr_in;
         orl_ff   <= orl_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         press_ff <= '0;
         rel_ff   <= '0;
         wp_ff    <= '0;
         count_ff <= '0;
         slot_ff  <= '0;
         clr_ff   <= '0;
         fired_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.frame_update) begin
            cur_ff   <= joy_ff;
            press_ff <= joy_ff & ~cur_ff;
            rel_ff   <= ~joy_ff & cur_ff;
            wp_ff    <= wp_in;
            slot_ff  <= '0;
            fired_ff <= 1'b0;
         end else if (cmd.next_slot) begin
            slot_ff <= slot_ff + 1'b1;
         end
         if (cmd.seq_hit) begin
            fired_ff <= 1'b1;
         end
         if (cmd.do_register && !table_full) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign rsp_tdata = {3'b000, orl_ff, opr_ff, oheld_ff, oslot_ff, oid_ff};
   assign rsp_tuser = okind_ff;
   assign rsp_tlast = olast_ff;

endmodule
`default_nettype wire

### rtl/bcsd_ctrl.sv
`default_nettype none
module bcsd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bcsd_pkg::dp_status_type status,
   output bcsd_pkg::dp_cmd_type         cmd,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_CMD_RD,
      S_CMD_EV,
      S_SEQ_RD,
      S_SEQ_CMP,
      S_WAIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.op)
               bcsd_pkg::OP_FRAME: begin
                  cmd.frame_update = 1'b1;
                  state_in         = S_CMD_RD;
               end
               bcsd_pkg::OP_REGISTER: begin
                  cmd.do_register = 1'b1;
                  cmd.load_out    = 1'b1;
                  cmd.out_sel     = bcsd_pkg::SEL_REGISTER;
                  cmd.out_last    = 1'b1;
                  state_in        = S_WAIT;
               end
               bcsd_pkg::OP_STEP: begin
                  cmd.step_write = 1'b1;
                  cmd.load_out   = 1'b1;
                  cmd.out_sel    = bcsd_pkg::SEL_STEP;
                  cmd.out_last   = 1'b1;
                  state_in       = S_WAIT;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_CMD_RD: begin
            if (status.slot_end) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = bcsd_pkg::SEL_SUMMARY;
               cmd.out_last = 1'b1;
               state_in     = S_WAIT;
            end else begin
               cmd.table_read = 1'b1;
               state_in       = S_CMD_EV;
            end
         end
         S_CMD_EV: begin
            priority if (status.simple_hit) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = bcsd_pkg::SEL_MATCH;
               state_in     = S_WAIT;
            end else if (status.is_seq && status.seq_ok) begin
               cmd.seq_init = 1'b1;
               state_in     = S_SEQ_RD;
            end else begin
               cmd.next_slot = 1'b1;
               state_in      = S_CMD_RD;
            end
         end
         S_SEQ_RD: begin
            if (status.window_done) begin
               cmd.next_slot = 1'b1;
               state_in      = S_CMD_RD;
            end else begin
               cmd.seq_read = 1'b1;
               state_in     = S_SEQ_CMP;
            end
         end
         S_SEQ_CMP: begin
            state_in = S_SEQ_RD;
            if (status.step_match) begin
               if (status.len_one) begin
                  cmd.seq_hit  = 1'b1;
                  cmd.load_out = 1'b1;
                  cmd.out_sel  = bcsd_pkg::SEL_MATCH;
                  state_in     = S_WAIT;
               end else begin
                  cmd.seq_advance = 1'b1;
               end
            end
         end
         S_WAIT: begin
            if (rsp_tready) begin
               if (status.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_slot = 1'b1;
                  state_in      = S_CMD_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_WAIT);

endmodule
`default_nettype wire

### rtl/button_command_sequence_detector.sv
`default_nettype none
// Channel    Dir  Ports                 Holds
// request    in   req_tdata, req_tuser  tuser: operation; tdata: command and step fields
// response   out  rsp_tdata, rsp_tuser  tuser: result_kind; tlast: last
//
// Register and step requests pass through accept, decode and response.
// A frame passes through accept, decode, a table read and evaluation for each registered
// command, a response for each match, and a table end with the summary; each sequence
// scan reads and compares one history entry at a time until it hits or its window runs out.
// After reset the history ring is cleared entry by entry, with no request taken.
// One request is worked at a time; a stalled response holds the controller.
module button_command_sequence_detector #(
   parameter int HISTORY_DEPTH = 60,
   parameter int MAX_COMMANDS  = 32,
   parameter int MAX_STEPS     = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // joypad, command_kind, trigger_mask, step_count, scan_frames,
   // command_tag, command_slot, step_index, step_mask
   input  wire logic [bcsd_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // matched_id, matched_slot, held_buttons, pressed_edges, released_edges
   output logic [bcsd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // result_kind
   output logic [2:0]                           rsp_tuser,
   output logic                                 rsp_tlast
);

   bcsd_pkg::dp_cmd_type    cmd;
   bcsd_pkg::dp_status_type status;

   bcsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   bcsd_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .MAX_COMMANDS  (MAX_COMMANDS),
      .MAX_STEPS     (MAX_STEPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
`default_nettype wire
